// ----- rtl/core/pd_attitude_mixer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// pd attitude mixer assertion macros
// clocked on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef PD_ATTITUDE_MIXER_UNIT_MACROS_SVH
`define PD_ATTITUDE_MIXER_UNIT_MACROS_SVH

// same-cycle implication
`define PDAM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PDAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pdam_pkg.sv -----
// ----------------------------------------------------------------------------
// pdam_pkg
// shared types and constants of the pd attitude mixer
// ----------------------------------------------------------------------------
package pdam_pkg;

   // shared multiplier operand and accumulator widths
   localparam int MA_W   = 17;
   localparam int MB_W   = 33;
   localparam int ACC_W  = MA_W + MB_W;

   // request kinds
   localparam logic [1:0] REQ_NAV  = 2'd0;
   localparam logic [1:0] REQ_GDN  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_CMD  = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GIMBAL_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRE_DEADBAND = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MOMENT_ARM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRUST_MIN    = 3'd5;

   // accumulator operations
   typedef enum logic [1:0] {
      MAC_IDLE = 2'd0,
      MAC_LOAD = 2'd1,
      MAC_SUB  = 2'd2,
      MAC_NEG  = 2'd3
   } mac_op_type;

   typedef struct packed {
      mac_op_type              op;
      logic signed [MA_W-1:0]  a;
      logic signed [MB_W-1:0]  b;
   } mac_req_type;

endpackage

// ----- rtl/core/pd_attitude_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// pd_attitude_mixer_unit
// pd attitude controller with gimbal / rcs torque mixing and firing deadband
// ----------------------------------------------------------------------------
// Navigation (req_tuser 0), guidance (1) and ground command (2'd3) transactions
// are accepted and give no result; they latch rates, targets, phase
// and thrust, or count commands. A control tick (req_tuser 2) gives exactly
// one result, and the unit takes no new transaction until the tick is done:
// the eight products of a tick (thrust times moment arm, then gain times
// error, gain times rate and gimbal times thrust-arm for pitch and yaw, and
// damping for roll) run one after another through a single 17x33 signed
// multiplier with a registered product and an accumulator, under a ten-step
// sequencer, and the done state forms the thruster mask and loads the output
// register. Torques are rounded from 2^-20 to 2^-8 Nm (nearest, ties up) and
// saturated to 32 bits. The result waits in an output register, so new
// transactions are accepted while it is held; a finished tick stalls only if
// the previous result has not yet been taken. Without navigation all result
// fields but tick_count are zero. Configuration writes are always accepted and
// must only be issued while the unit is idle.
// ----------------------------------------------------------------------------
`include "pd_attitude_mixer_unit_macros.svh"

module pd_attitude_mixer_unit
   import pdam_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // roll, pitch and yaw body rates, pitch_target, yaw_target,
   // guidance_phase, thrust_newtons, zero pad
   input  logic [111:0]          req_tdata,
   // req_type
   input  logic [1:0]            req_tuser,

   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // gimbal_pitch, gimbal_yaw, roll_torque, pitch_torque, yaw_torque,
   // thruster_mask, tick_count, zero pad
   output logic [167:0]          rsp_tdata,
   // powered_mode
   output logic [0:0]            rsp_tuser,

   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [19:0]           csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic [3:0] STEP_LAST = 4'd9;

   // round 2^-20 to 2^-8, ties toward +inf, then saturate to 32 bits
   function automatic logic signed [31:0] round_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W:0]    s;
      logic signed [ACC_W-12:0] q;
      s = {v[ACC_W-1], v} + (ACC_W+1)'(2048);
      q = s[ACC_W:12];
      if (q > (ACC_W-11)'(64'sd2147483647)) begin
         round_sat = 32'sh7FFF_FFFF;
      end else if (q < -(ACC_W-11)'(64'sd2147483648)) begin
         round_sat = 32'sh8000_0000;
      end else begin
         round_sat = q[31:0];
      end
   endfunction

   // {negative fire, positive fire}
   function automatic logic [1:0] fire_pair(input logic signed [31:0] t,
                                            input logic [15:0] db);
      logic signed [32:0] tw;
      logic signed [32:0] dp;
      tw = {t[31], t};
      dp = $signed({17'b0, db});
      fire_pair = {(tw < -dp), (tw > dp)};
   endfunction

   function automatic logic signed [15:0] clamp_angle(input logic signed [15:0] e,
                                                      input logic [14:0] lim);
      logic signed [16:0] ew;
      logic signed [16:0] lw;
      ew = {e[15], e};
      lw = $signed({2'b0, lim});
      if (ew < -lw) begin
         clamp_angle = 16'(-lw);
      end else if (ew > lw) begin
         clamp_angle = lw[15:0];
      end else begin
         clamp_angle = e;
      end
   endfunction

   // configuration registers
   logic [15:0] prop_gain_ff, prop_gain_in;
   logic [15:0] rate_gain_ff, rate_gain_in;
   logic [14:0] gimbal_limit_ff, gimbal_limit_in;
   logic [15:0] fire_deadband_ff, fire_deadband_in;
   logic [11:0] moment_arm_ff, moment_arm_in;
   logic [19:0] thrust_min_ff, thrust_min_in;

   // held navigation / guidance state
   logic               nav_seen_ff, nav_seen_in;
   logic               guide_seen_ff, guide_seen_in;
   logic signed [15:0] rate_r_ff, rate_r_in;
   logic signed [15:0] rate_p_ff, rate_p_in;
   logic signed [15:0] rate_y_ff, rate_y_in;
   logic signed [15:0] target_p_ff, target_p_in;
   logic signed [15:0] target_y_ff, target_y_in;
   logic [7:0]         phase_ff, phase_in;
   logic [19:0]        thrust_ff, thrust_in;
   logic [31:0]        tick_counter_ff, tick_counter_in;
   logic [15:0]        command_counter_ff, command_counter_in;

   // sequencer and working registers
   state_type          state_ff, state_in;
   logic [3:0]         step_ff, step_in;
   logic [31:0]        ta_ff, ta_in;
   logic signed [31:0] tq_r_ff, tq_r_in;
   logic signed [31:0] tq_p_ff, tq_p_in;
   logic signed [31:0] tq_y_ff, tq_y_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [167:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_power_ff, rsp_power_in;

   logic                     req_fire;
   logic                     load_rsp;
   logic                     powered;
   logic signed [15:0]       err_p;
   logic signed [15:0]       err_y;
   logic signed [15:0]       gim_p;
   logic signed [15:0]       gim_y;
   logic [5:0]               mask;
   mac_req_type              mac_req;
   logic signed [ACC_W-1:0]  acc;

   pdam_mac u_mac (
      .clock (clock),
      .reset (reset),
      .req   (mac_req),
      .acc   (acc)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // mode and gimbal angles come from held state, stable through a tick
   assign powered = guide_seen_ff && (phase_ff != 8'd0) && (thrust_ff > thrust_min_ff);
   assign err_p   = guide_seen_ff ? target_p_ff : 16'sd0;
   assign err_y   = guide_seen_ff ? target_y_ff : 16'sd0;
   assign gim_p   = powered ? clamp_angle(err_p, gimbal_limit_ff) : 16'sd0;
   assign gim_y   = powered ? clamp_angle(err_y, gimbal_limit_ff) : 16'sd0;
   assign mask    = {fire_pair(tq_y_ff, fire_deadband_ff),
                     fire_pair(tq_p_ff, fire_deadband_ff),
                     fire_pair(tq_r_ff, fire_deadband_ff)};

   // multiplier schedule: operands issued per step
   always_comb begin
      mac_req.op = MAC_IDLE;
      mac_req.a  = '0;
      mac_req.b  = '0;
      if (state_ff == ST_RUN) begin
         case (step_ff)
            4'd0: begin   // thrust times moment arm
               mac_req.op = MAC_LOAD;
               mac_req.a  = $signed({5'b0, moment_arm_ff});
               mac_req.b  = $signed({13'b0, thrust_ff});
            end
            4'd1: begin
               mac_req.op = MAC_LOAD;
               mac_req.a  = $signed({1'b0, prop_gain_ff});
               mac_req.b  = MB_W'(err_p);
            end
            4'd2: begin
               mac_req.op = MAC_SUB;
               mac_req.a  = $signed({1'b0, rate_gain_ff});
               mac_req.b  = MB_W'(rate_p_ff);
            end
            4'd3: begin
               mac_req.op = MAC_SUB;
               mac_req.a  = MA_W'(gim_p);
               mac_req.b  = $signed({1'b0, ta_ff});
            end
            4'd4: begin
               mac_req.op = MAC_LOAD;
               mac_req.a  = $signed({1'b0, prop_gain_ff});
               mac_req.b  = MB_W'(err_y);
            end
            4'd5: begin
               mac_req.op = MAC_SUB;
               mac_req.a  = $signed({1'b0, rate_gain_ff});
               mac_req.b  = MB_W'(rate_y_ff);
            end
            4'd6: begin
               mac_req.op = MAC_SUB;
               mac_req.a  = MA_W'(gim_y);
               mac_req.b  = $signed({1'b0, ta_ff});
            end
            4'd7: begin   // roll has damping only
               mac_req.op = MAC_NEG;
               mac_req.a  = $signed({1'b0, rate_gain_ff});
               mac_req.b  = MB_W'(rate_r_ff);
            end
            default: begin
               mac_req.op = MAC_IDLE;
            end
         endcase
      end
   end

   // next-state logic
   always_comb begin
      prop_gain_in       = prop_gain_ff;
      rate_gain_in       = rate_gain_ff;
      gimbal_limit_in    = gimbal_limit_ff;
      fire_deadband_in   = fire_deadband_ff;
      moment_arm_in      = moment_arm_ff;
      thrust_min_in      = thrust_min_ff;
      nav_seen_in        = nav_seen_ff;
      guide_seen_in      = guide_seen_ff;
      rate_r_in          = rate_r_ff;
      rate_p_in          = rate_p_ff;
      rate_y_in          = rate_y_ff;
      target_p_in        = target_p_ff;
      target_y_in        = target_y_ff;
      phase_in           = phase_ff;
      thrust_in          = thrust_ff;
      tick_counter_in    = tick_counter_ff;
      command_counter_in = command_counter_ff;
      state_in           = state_ff;
      step_in            = step_ff;
      ta_in              = ta_ff;
      tq_r_in            = tq_r_ff;
      tq_p_in            = tq_p_ff;
      tq_y_in            = tq_y_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_data_in        = rsp_data_ff;
      rsp_power_in       = rsp_power_ff;

      // register writes, indexes past the list are dropped
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:     prop_gain_in     = csr_data[15:0];
            CSR_RATE_GAIN:     rate_gain_in     = csr_data[15:0];
            CSR_GIMBAL_LIMIT:  gimbal_limit_in  = csr_data[14:0];
            CSR_FIRE_DEADBAND: fire_deadband_in = csr_data[15:0];
            CSR_MOMENT_ARM:    moment_arm_in    = csr_data[11:0];
            CSR_THRUST_MIN:    thrust_min_in    = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  REQ_NAV: begin
                     rate_r_in   = req_tdata[15:0];
                     rate_p_in   = req_tdata[31:16];
                     rate_y_in   = req_tdata[47:32];
                     nav_seen_in = 1'b1;
                  end
                  REQ_GDN: begin
                     target_p_in   = req_tdata[63:48];
                     target_y_in   = req_tdata[79:64];
                     phase_in      = req_tdata[87:80];
                     thrust_in     = req_tdata[107:88];
                     guide_seen_in = 1'b1;
                  end
                  REQ_TICK: begin
                     state_in = ST_RUN;
                     step_in  = 4'd0;
                  end
                  default: begin   // ground command
                     command_counter_in = command_counter_ff + 16'd1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            // capture points follow the registered product and accumulator of the multiply-accumulate
            case (step_ff)
               4'd2:    ta_in   = acc[31:0];
               4'd5:    tq_p_in = round_sat(acc);
               4'd8:    tq_y_in = round_sat(acc);
               4'd9:    tq_r_in = round_sat(acc);
               default: ;
            endcase
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = nav_seen_ff && powered;
               if (nav_seen_ff) begin
                  rsp_data_in = {2'b0, tick_counter_ff, mask, tq_y_ff, tq_p_ff, tq_r_ff,
                                 gim_y, gim_p};
               end else begin
                  rsp_data_in = {2'b0, tick_counter_ff, 134'b0};
               end
               tick_counter_in = tick_counter_ff + 32'd1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff       <= 16'd2048;
         rate_gain_ff       <= 16'd1024;
         gimbal_limit_ff    <= 15'd430;
         fire_deadband_ff   <= 16'd26;
         moment_arm_ff      <= 12'd384;
         thrust_min_ff      <= 20'd100;
         nav_seen_ff        <= 1'b0;
         guide_seen_ff      <= 1'b0;
         rate_r_ff          <= '0;
         rate_p_ff          <= '0;
         rate_y_ff          <= '0;
         target_p_ff        <= '0;
         target_y_ff        <= '0;
         phase_ff           <= '0;
         thrust_ff          <= '0;
         tick_counter_ff    <= '0;
         command_counter_ff <= '0;
         state_ff           <= ST_IDLE;
         step_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         prop_gain_ff       <= prop_gain_in;
         rate_gain_ff       <= rate_gain_in;
         gimbal_limit_ff    <= gimbal_limit_in;
         fire_deadband_ff   <= fire_deadband_in;
         moment_arm_ff      <= moment_arm_in;
         thrust_min_ff      <= thrust_min_in;
         nav_seen_ff        <= nav_seen_in;
         guide_seen_ff      <= guide_seen_in;
         rate_r_ff          <= rate_r_in;
         rate_p_ff          <= rate_p_in;
         rate_y_ff          <= rate_y_in;
         target_p_ff        <= target_p_in;
         target_y_ff        <= target_y_in;
         phase_ff           <= phase_in;
         thrust_ff          <= thrust_in;
         tick_counter_ff    <= tick_counter_in;
         command_counter_ff <= command_counter_in;
         state_ff           <= state_in;
         step_ff            <= step_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      // datapath registers
      ta_ff        <= ta_in;
      tq_r_ff      <= tq_r_in;
      tq_p_ff      <= tq_p_in;
      tq_y_ff      <= tq_y_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_power_ff;

   // each delivered tick advances the tick count by exactly one
   `PDAM_ASSERT_NEXT(a_tick_advance, load_rsp,
                     tick_counter_ff == $past(tick_counter_ff) + 32'd1,
                     "tick counter did not advance on result load")
   // gimbals stay at zero outside powered flight
   `PDAM_ASSERT_NOW(a_gimbal_zero, rsp_tvalid && !rsp_tuser[0],
                    rsp_tdata[31:0] == 32'd0,
                    "nonzero gimbal in unpowered result")
   // sequencer never runs past its last step
   `PDAM_ASSERT_NOW(a_step_range, state_ff == ST_RUN, step_ff <= STEP_LAST,
                    "sequencer step out of range")

endmodule

// ----- rtl/core/pdam_mac.sv -----
// ----------------------------------------------------------------------------
// pdam_mac
// shared signed multiplier with registered product and accumulator
// ----------------------------------------------------------------------------
module pdam_mac
   import pdam_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_req_type              req,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [ACC_W-1:0] prod_ff, prod_in;
   mac_op_type              op_ff, op_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // product is registered in the cycle after issue, and accumulated in the cycle after that
   always_comb begin
      prod_in = req.a * req.b;
      op_in   = req.op;
      case (op_ff)
         MAC_LOAD: acc_in = prod_ff;
         MAC_SUB:  acc_in = acc_ff - prod_ff;
         MAC_NEG:  acc_in = -prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_IDLE;
      end else begin
         op_ff <= op_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- dv/pd_attitude_mixer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pd_attitude_mixer_unit_tb
// self-checking bench: requests stream in from a queue, a predictor of the pd
// law, gimbal/rcs mix and deadband builds the expected tick results, and every
// returned result is compared field by field under random flow control
// ----------------------------------------------------------------------------
module pd_attitude_mixer_unit_tb
   import pdam_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // indexes past the register file, writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int QUIET_LIMIT  = 20000;   // cycles with no transaction at all
   localparam int SETTLE_LAST  = 16;      // covers a full tick sequence, plus margin
   localparam int SINK_FREEZE  = 400;     // long receiver hold-off
   localparam int PHASE_ITEMS  = 222;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] roll_omega;
      logic signed [15:0] pitch_omega;
      logic signed [15:0] yaw_omega;
      logic signed [15:0] pitch_target;
      logic signed [15:0] yaw_target;
      logic [7:0]         phase;
      logic [19:0]        thrust;
   } attitude_req_type;

   typedef struct packed {
      logic signed [15:0] gimbal_pitch;
      logic signed [15:0] gimbal_yaw;
      logic signed [31:0] roll_torque;
      logic signed [31:0] pitch_torque;
      logic signed [31:0] yaw_torque;
      logic [5:0]         thruster_mask;
      logic               powered;
      logic [31:0]        tick_count;
   } attitude_rsp_type;

   logic clock = 1'b0;
   logic reset;

   logic                 req_tvalid;
   logic                 req_tready;
   logic [111:0]         req_tdata;
   logic [1:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [167:0]         rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [19:0]          csr_data;

   // requests waiting for the driver, results waiting for the monitor
   attitude_req_type pending_reqs[$];
   attitude_rsp_type ticks_due[$];
   attitude_req_type req_cur;
   attitude_rsp_type rsp_seen;
   attitude_rsp_type rsp_want;

   // flow control knobs set by the sequence
   logic src_open     = 1'b0;
   int   src_idle_pct  = 0;
   int   sink_idle_pct = 0;
   logic freeze_arm   = 1'b0;
   logic sink_frozen  = 1'b0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // predictor copy of the registers, reset values
   int kp_gain      = 2048;
   int kd_gain      = 1024;
   int gimbal_lim   = 430;
   int deadband     = 26;
   int arm_q48      = 384;
   int thrust_floor = 100;

   // predictor copy of the latched inputs
   logic        nav_valid   = 1'b0;
   logic        guide_valid = 1'b0;
   int          rate_roll   = 0;
   int          rate_pitch  = 0;
   int          rate_yaw    = 0;
   int          tgt_pitch   = 0;
   int          tgt_yaw     = 0;
   int          held_phase  = 0;
   int          held_thrust = 0;
   logic [31:0] tick_total  = '0;

   pd_attitude_mixer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // round 2^-20 to 2^-8 nearest with ties up, then saturate to 32 bits
   function automatic logic signed [31:0] to_torque(longint v);
      longint q;
      q = (v + 2048) >>> 12;
      if (q > 64'sd2147483647) return 32'sh7fff_ffff;
      if (q < -64'sd2147483648) return 32'sh8000_0000;
      return q[31:0];
   endfunction

   // {negative, positive} thruster pair outside the deadband
   function automatic logic [1:0] fire_pair(logic signed [31:0] t);
      longint tq;
      tq = t;
      return {tq < -longint'(deadband), tq > longint'(deadband)};
   endfunction

   function automatic int clamp_gimbal(int a);
      if (a < -gimbal_lim) return -gimbal_lim;
      if (a > gimbal_lim) return gimbal_lim;
      return a;
   endfunction

   function automatic attitude_rsp_type mix_tick();
      attitude_rsp_type r;
      longint           e_p, e_y, t_r, t_p, t_y, thrust_arm;
      int               g_p, g_y;
      r = '0;
      r.tick_count = tick_total;
      if (nav_valid) begin
         // roll error is always zero, pitch/yaw errors need guidance
         e_p = guide_valid ? tgt_pitch : 0;
         e_y = guide_valid ? tgt_yaw : 0;
         t_r = -longint'(kd_gain) * rate_roll;
         t_p = kp_gain * e_p - longint'(kd_gain) * rate_pitch;
         t_y = kp_gain * e_y - longint'(kd_gain) * rate_yaw;
         g_p = 0;
         g_y = 0;
         if (guide_valid && held_phase != 0 && held_thrust > thrust_floor) begin
            // powered flight, gimbal takes its share and rcs the residual
            thrust_arm = longint'(held_thrust) * arm_q48;
            g_p = clamp_gimbal(int'(e_p));
            g_y = clamp_gimbal(int'(e_y));
            t_p = t_p - g_p * thrust_arm;
            t_y = t_y - g_y * thrust_arm;
            r.powered = 1'b1;
         end
         r.gimbal_pitch  = 16'(g_p);
         r.gimbal_yaw    = 16'(g_y);
         r.roll_torque   = to_torque(t_r);
         r.pitch_torque  = to_torque(t_p);
         r.yaw_torque    = to_torque(t_y);
         r.thruster_mask = {fire_pair(r.yaw_torque), fire_pair(r.pitch_torque),
                            fire_pair(r.roll_torque)};
      end
      return r;
   endfunction

   function automatic void apply_request(attitude_req_type it);
      case (it.kind)
         REQ_NAV: begin
            rate_roll  = it.roll_omega;
            rate_pitch = it.pitch_omega;
            rate_yaw   = it.yaw_omega;
            nav_valid  = 1'b1;
         end
         REQ_GDN: begin
            tgt_pitch   = it.pitch_target;
            tgt_yaw     = it.yaw_target;
            held_phase  = it.phase;
            held_thrust = it.thrust;
            guide_valid = 1'b1;
         end
         REQ_TICK: begin
            ticks_due.push_back(mix_tick());
            tick_total = tick_total + 1;
         end
         default: ;   // ground command only bumps an internal counter
      endcase
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [19:0] val);
      case (idx)
         CSR_PROP_GAIN:     kp_gain      = val[15:0];
         CSR_RATE_GAIN:     kd_gain      = val[15:0];
         CSR_GIMBAL_LIMIT:  gimbal_lim   = val[14:0];
         CSR_FIRE_DEADBAND: deadband     = val[15:0];
         CSR_MOMENT_ARM:    arm_q48      = val[11:0];
         CSR_THRUST_MIN:    thrust_floor = val[19:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         // prediction follows the transaction order seen by the block
         if (req_tvalid && req_tready) begin
            apply_request(req_cur);
         end
         if (!req_tvalid || req_tready) begin
            if (src_open && pending_reqs.size() != 0 &&
                $urandom_range(0, 99) >= src_idle_pct) begin
               req_cur = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               // tdata from the lowest bit up, four pad bits on top
               req_tdata  <= {4'b0, req_cur.thrust, req_cur.phase, req_cur.yaw_target,
                              req_cur.pitch_target, req_cur.yaw_omega, req_cur.pitch_omega,
                              req_cur.roll_omega};
               req_tuser  <= req_cur.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor and receiver back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen.gimbal_pitch  = rsp_tdata[15:0];
            rsp_seen.gimbal_yaw    = rsp_tdata[31:16];
            rsp_seen.roll_torque   = rsp_tdata[63:32];
            rsp_seen.pitch_torque  = rsp_tdata[95:64];
            rsp_seen.yaw_torque    = rsp_tdata[127:96];
            rsp_seen.thruster_mask = rsp_tdata[133:128];
            rsp_seen.tick_count    = rsp_tdata[165:134];
            rsp_seen.powered       = rsp_tuser[0];
            if (ticks_due.size() == 0) begin
               $display("%0t: result with no tick pending, expected none, actual tick %0d",
                        $time, rsp_seen.tick_count);
               mismatch_count++;
            end else begin
               rsp_want = ticks_due.pop_front();
               check_field("gimbal_pitch", rsp_want.gimbal_pitch, rsp_seen.gimbal_pitch);
               check_field("gimbal_yaw", rsp_want.gimbal_yaw, rsp_seen.gimbal_yaw);
               check_field("roll_torque", rsp_want.roll_torque, rsp_seen.roll_torque);
               check_field("pitch_torque", rsp_want.pitch_torque, rsp_seen.pitch_torque);
               check_field("yaw_torque", rsp_want.yaw_torque, rsp_seen.yaw_torque);
               check_field("thruster_mask", rsp_want.thruster_mask, rsp_seen.thruster_mask);
               check_field("powered_mode", rsp_want.powered, rsp_seen.powered);
               check_field("tick_count", rsp_want.tick_count, rsp_seen.tick_count);
            end
         end
         rsp_tready <= !sink_frozen && ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   // long receiver hold-off, counted here while the sender keeps offering
   initial begin
      wait (freeze_arm);
      @(posedge clock);
      sink_frozen <= 1'b1;
      repeat (SINK_FREEZE) @(posedge clock);
      sink_frozen <= 1'b0;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic attitude_req_type mk_item(logic [1:0] kind, int rr, int pr, int yr,
                                                int pt, int yt, int ph, int th);
      attitude_req_type it;
      it.kind         = kind;
      it.roll_omega   = 16'(rr);
      it.pitch_omega  = 16'(pr);
      it.yaw_omega    = 16'(yr);
      it.pitch_target = 16'(pt);
      it.yaw_target   = 16'(yt);
      it.phase        = 8'(ph);
      it.thrust       = 20'(th);
      return it;
   endfunction

   // angles and rates lean on the extremes and on small values near zero
   function automatic int rand_angle();
      case ($urandom_range(0, 7))
         0: return 32767;
         1: return -32768;
         2: return 0;
         3: return int'($urandom_range(0, 1200)) - 600;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // thrust around the powered threshold now configured
   function automatic int rand_thrust();
      case ($urandom_range(0, 5))
         0: return thrust_floor;
         1: return (thrust_floor + 1) & 20'hFFFFF;
         2: return 0;
         3: return 20'hFFFFF;
         default: return $urandom_range(0, 20'hFFFFF);
      endcase
   endfunction

   function automatic attitude_req_type rand_item(logic [1:0] kind);
      int ph;
      case ($urandom_range(0, 3))
         0: ph = 0;
         1: ph = 255;
         default: ph = $urandom_range(0, 255);
      endcase
      return mk_item(kind, rand_angle(), rand_angle(), rand_angle(), rand_angle(),
                     rand_angle(), ph, rand_thrust());
   endfunction

   // mostly nav, optional guidance, then one or two ticks; the rest is noise
   task automatic queue_traffic(input int n_items);
      int made;
      int pick;
      made = 0;
      while (made < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            pending_reqs.push_back(rand_item(REQ_NAV));
            made++;
            if ($urandom_range(0, 1)) begin
               pending_reqs.push_back(rand_item(REQ_GDN));
               made++;
            end
            repeat ($urandom_range(1, 2)) begin
               pending_reqs.push_back(rand_item(REQ_TICK));
               made++;
            end
         end else if (pick < 88) begin
            pending_reqs.push_back(rand_item(2'($urandom_range(REQ_NAV, REQ_TICK))));
            made++;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               pending_reqs.push_back(rand_item(REQ_CMD));
               made++;
            end
         end
      end
   endtask

   // one register transaction on the write channel
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [19:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   task automatic load_regs(input logic [19:0] kp, input logic [19:0] kd,
                            input logic [19:0] lim, input logic [19:0] db,
                            input logic [19:0] arm, input logic [19:0] tmin);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_RATE_GAIN, kd);
      write_reg(CSR_GIMBAL_LIMIT, lim);
      write_reg(CSR_FIRE_DEADBAND, db);
      write_reg(CSR_MOMENT_ARM, arm);
      write_reg(CSR_THRUST_MIN, tmin);
      write_reg($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7, 20'($urandom));
   endtask

   // let the queue empty and every tick come back, then let the block settle
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || ticks_due.size() != 0)
         @(posedge clock);
      src_open <= 1'b0;
      repeat (SETTLE_LAST) @(posedge clock);
   endtask

   task automatic run_phase(input int n_items, input int src_pct, input int sink_pct,
                            input bit pause_mid);
      int half;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      queue_traffic(n_items);
      half = pending_reqs.size() / 2;
      @(posedge clock);
      src_open <= 1'b1;
      if (pause_mid) begin
         // sender stops halfway until every tick result is back
         while (pending_reqs.size() > half) @(posedge clock);
         src_open <= 1'b0;
         @(posedge clock);
         while (req_tvalid || ticks_due.size() != 0) @(posedge clock);
         src_open <= 1'b1;
      end
      drain();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_NAV;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_PROP_GAIN;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset configuration
      pending_reqs.push_back(mk_item(REQ_TICK, 5, 6, 7, 8, 9, 1, 500));      // no nav yet
      pending_reqs.push_back(mk_item(REQ_CMD, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_NAV, 32767, -32768, 32767, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));        // no guidance
      // roll lands on the deadband, yaw just past it, pitch on the negative edge
      pending_reqs.push_back(mk_item(REQ_NAV, -104, 104, -108, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_GDN, 0, 0, 0, 200, -300, 0, 5000)); // phase zero
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_GDN, 0, 0, 0, 200, -300, 1, 100));  // thrust at floor
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_GDN, 0, 0, 0, 200, -300, 255, 101)); // powered
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      // targets past the gimbal limit, full thrust
      pending_reqs.push_back(mk_item(REQ_GDN, 0, 0, 0, 32767, -32768, 255, 20'hFFFFF));
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_NAV, -32768, 32767, -32768, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_NAV, -2, 2, 6, 0, 0, 0, 0));        // rounding ties
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_GDN, 0, 0, 0, -1, 1, 128, 0));      // zero thrust
      pending_reqs.push_back(mk_item(REQ_CMD, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_NAV, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_item(REQ_TICK, 0, 0, 0, 0, 0, 0, 0));        // back to back
      pending_reqs.push_back(mk_item(REQ_CMD, 0, 0, 0, 0, 0, 0, 0));
      src_idle_pct  = 10;
      sink_idle_pct = 55;
      src_open <= 1'b1;
      drain();

      // every register at its maximum, extra data bits set, never powered
      load_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      run_phase(PHASE_ITEMS, 10, 55, 1'b0);

      // full gains and arm with no threshold: residuals saturate
      // receiver holds off for a long stretch so the input stalls
      load_regs(20'hFFFF, 20'hFFFF, 20'h7FFF, 20'h0, 20'hFFF, 20'h0);
      freeze_arm <= 1'b1;
      run_phase(PHASE_ITEMS, 10, 55, 1'b0);

      // everything zero
      load_regs(20'h0, 20'h0, 20'h0, 20'h0, 20'h0, 20'h0);
      run_phase(PHASE_ITEMS, 55, 10, 1'b0);

      // random registers, sender pauses midway until all results are back
      load_regs(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom_range(0, 4000)),
                20'($urandom), 20'($urandom_range(0, 300000)));
      run_phase(PHASE_ITEMS, 55, 10, 1'b1);

      load_regs(20'($urandom), 20'($urandom), 20'($urandom_range(0, 2000)),
                20'($urandom_range(0, 70000)), 20'($urandom), 20'($urandom_range(0, 5000)));
      run_phase(PHASE_ITEMS, 0, 0, 1'b0);

      // back to the reset values
      load_regs(20'd2048, 20'd1024, 20'd430, 20'd26, 20'd384, 20'd100);
      run_phase(PHASE_ITEMS, 0, 0, 1'b0);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
